// ===== rtl/core/fexp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fexp_pkg - shared types, constants and arithmetic for the exponential block
// Binary32 arithmetic with round to nearest even and full subnormal support.
// ----------------------------------------------------------------------------
package fexp_pkg;

    localparam int LANES  = 4;
    localparam int STAGES = 11;

    typedef logic signed [9:0] t_exp;

    typedef struct packed {
        logic        special;
        logic [31:0] spec_val;
        logic        sign;
        t_exp        top;
        logic [79:0] mag;
    } t_fma_mid;

    localparam logic [31:0] C_QNAN    = 32'h7FC0_0000;
    localparam logic [31:0] C_INV_LN2 = 32'h3FB8_AA3B;
    localparam logic [31:0] C_LN2     = 32'h3F31_7218;
    localparam logic [31:0] C_POLY [8] = '{
        32'h3F80_0000, 32'h3D2A_A390, 32'h3F00_000A, 32'h3AB9_1BCB,
        32'h3F80_0001, 32'h3C08_97A6, 32'h3E2A_AA6A, 32'h394D_4A8B
    };
    localparam logic signed [31:0] C_M_FLOOR = -32'sd126;
    localparam logic signed [31:0] C_M_SHMAX = 32'sd255;

    function automatic logic [6:0] lzc80(input logic [79:0] v);
        logic [6:0] cnt;
        cnt = 7'd80;
        for (int i = 0; i < 80; i++) begin
            if (v[i]) begin
                cnt = 7'(79 - i);
            end
        end
        return cnt;
    endfunction

    function automatic logic [79:0] shr_sticky80(input logic [79:0] v, input logic [9:0] sh);
        logic [79:0] res;
        if (sh >= 10'd80) begin
            res = {79'b0, |v};
        end else begin
            res = (v >> sh) | {79'b0, |(v & ((80'd1 << sh) - 80'd1))};
        end
        return res;
    endfunction

    // Denormalise if needed, then round to nearest even and pack.
    function automatic logic [31:0] round_pack(input logic sign, input t_exp e,
                                               input logic [26:0] sig);
        logic [26:0] s;
        t_exp        ee;
        logic [9:0]  sh;
        logic [23:0] m24;
        logic        inc;
        logic [32:0] bits;
        s  = sig;
        ee = e;
        if (ee < 10'sd1) begin
            sh = 10'(10'sd1 - ee);
            if (sh >= 10'd27) begin
                s = {26'b0, |s};
            end else begin
                s = (s >> sh) | {26'b0, |(s & ((27'd1 << sh) - 27'd1))};
            end
            ee = 10'sd1;
        end
        if (ee >= 10'sd255) begin
            return {sign, 8'hFF, 23'b0};
        end
        m24  = s[26:3];
        inc  = s[2] & (s[1] | s[0] | s[3]);
        bits = {ee - 10'sd1, 23'b0};
        bits = bits + {9'b0, m24} + {32'b0, inc};
        return {sign, bits[30:0]};
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic        sgn, nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
        logic [23:0] ma, mb;
        logic [47:0] p, n;
        logic [6:0]  lz;
        t_exp        e;
        sgn   = a[31] ^ b[31];
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        zer_a = (a[30:0] == '0);
        zer_b = (b[30:0] == '0);
        if (nan_a || nan_b || (inf_a && zer_b) || (zer_a && inf_b)) begin
            return C_QNAN;
        end
        if (inf_a || inf_b) begin
            return {sgn, 8'hFF, 23'b0};
        end
        if (zer_a || zer_b) begin
            return {sgn, 31'b0};
        end
        ma = {a[30:23] != '0, a[22:0]};
        mb = {b[30:23] != '0, b[22:0]};
        p  = ma * mb;
        lz = lzc80({p, 32'b0});
        n  = p << lz;
        e  = t_exp'({2'b0, (a[30:23] == '0) ? 8'd1 : a[30:23]})
           + t_exp'({2'b0, (b[30:23] == '0) ? 8'd1 : b[30:23]})
           - 10'sd126 - t_exp'({3'b0, lz});
        return round_pack(sgn, e, {n[47:22], |n[21:0]});
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic        nan_a, nan_b, inf_a, inf_b, sub, s_l;
        logic [31:0] big, sml;
        logic [7:0]  e_l, e_s, d;
        logic [26:0] av, bv0, bv;
        logic [27:0] sum, n;
        logic [6:0]  lz;
        t_exp        e;
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
            return C_QNAN;
        end
        if (inf_a) begin
            return a;
        end
        if (inf_b) begin
            return b;
        end
        if (b[30:0] > a[30:0]) begin
            big = b;
            sml = a;
        end else begin
            big = a;
            sml = b;
        end
        sub = a[31] ^ b[31];
        s_l = big[31];
        e_l = (big[30:23] == '0) ? 8'd1 : big[30:23];
        e_s = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
        d   = e_l - e_s;
        av  = {big[30:23] != '0, big[22:0], 3'b0};
        bv0 = {sml[30:23] != '0, sml[22:0], 3'b0};
        if (d >= 8'd27) begin
            bv = {26'b0, |bv0};
        end else begin
            bv = (bv0 >> d) | {26'b0, |(bv0 & ((27'd1 << d) - 27'd1))};
        end
        sum = sub ? ({1'b0, av} - {1'b0, bv}) : ({1'b0, av} + {1'b0, bv});
        if (sum == '0) begin
            return sub ? 32'h0 : {a[31], 31'b0};
        end
        lz = lzc80({sum, 52'b0});
        n  = sum << lz;
        e  = t_exp'({2'b0, e_l}) + 10'sd1 - t_exp'({3'b0, lz});
        return round_pack(s_l, e, {n[27:2], |n[1:0]});
    endfunction

    // Truncate toward zero with saturation; NaN gives zero.
    function automatic logic signed [31:0] trunc_sat(input logic [31:0] f);
        logic [31:0] mag;
        logic [7:0]  sh;
        if ((f[30:23] == 8'hFF) && (f[22:0] != '0)) begin
            return 32'sd0;
        end
        if (f[30:23] >= 8'd158) begin
            return f[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        if (f[30:23] < 8'd127) begin
            return 32'sd0;
        end
        sh  = 8'd157 - f[30:23];
        mag = ({1'b1, f[22:0], 8'b0} >> 1) >> sh;
        return f[31] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [31:0] i2f(input logic signed [31:0] m);
        logic [31:0] mag, n;
        logic [6:0]  lz;
        if (m == 32'sd0) begin
            return 32'h0;
        end
        mag = m[31] ? 32'(-m) : 32'(m);
        lz  = lzc80({mag, 48'b0});
        n   = mag << lz;
        return round_pack(m[31], 10'sd158 - t_exp'({3'b0, lz}), {n[31:6], |n[5:0]});
    endfunction

    // First half of a - b*c: exact product, alignment and magnitude sum.
    function automatic t_fma_mid fma_align(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
        t_fma_mid    r;
        logic        sq, nan_x, inf_a, inf_p, zer_a, zer_p;
        logic [47:0] p;
        t_exp        top_a, top_p, top;
        logic [79:0] aw, pw;
        r     = '0;
        sq    = ~(b[31] ^ c[31]);
        nan_x = ((a[30:23] == 8'hFF) && (a[22:0] != '0))
             || ((b[30:23] == 8'hFF) && (b[22:0] != '0))
             || ((c[30:23] == 8'hFF) && (c[22:0] != '0));
        inf_a = (a[30:0] == 31'h7F80_0000);
        inf_p = (b[30:0] == 31'h7F80_0000) || (c[30:0] == 31'h7F80_0000);
        zer_a = (a[30:0] == '0);
        zer_p = (b[30:0] == '0) || (c[30:0] == '0);
        r.special = 1'b1;
        if (nan_x || (inf_p && zer_p) || (inf_a && inf_p && (a[31] != sq))) begin
            r.spec_val = C_QNAN;
        end else if (inf_a) begin
            r.spec_val = a;
        end else if (inf_p) begin
            r.spec_val = {sq, 8'hFF, 23'b0};
        end else if (zer_p) begin
            r.spec_val = zer_a ? {a[31] & sq, 31'b0} : a;
        end else begin
            r.special = 1'b0;
            p     = {b[30:23] != '0, b[22:0]} * {c[30:23] != '0, c[22:0]};
            top_a = t_exp'({2'b0, (a[30:23] == '0) ? 8'd1 : a[30:23]}) - 10'sd127;
            top_p = t_exp'({2'b0, (b[30:23] == '0) ? 8'd1 : b[30:23]})
                  + t_exp'({2'b0, (c[30:23] == '0) ? 8'd1 : c[30:23]}) - 10'sd253;
            top   = ((top_a > top_p) ? top_a : top_p) + 10'sd1;
            aw    = shr_sticky80({a[30:23] != '0, a[22:0], 56'b0}, 10'(top - top_a));
            pw    = shr_sticky80({p, 32'b0}, 10'(top - top_p));
            r.top = top;
            if (a[31] == sq) begin
                r.mag  = aw + pw;
                r.sign = a[31];
            end else if (aw >= pw) begin
                r.mag  = aw - pw;
                r.sign = a[31];
            end else begin
                r.mag  = pw - aw;
                r.sign = sq;
            end
        end
        return r;
    endfunction

    // Second half: normalise the aligned sum and round once.
    function automatic logic [31:0] fma_norm(input t_fma_mid mid);
        logic [6:0]  lz;
        logic [79:0] n;
        if (mid.special) begin
            return mid.spec_val;
        end
        if (mid.mag == '0) begin
            return 32'h0;
        end
        lz = lzc80(mid.mag);
        n  = mid.mag << lz;
        return round_pack(mid.sign, mid.top - t_exp'({3'b0, lz}) + 10'sd127,
                          {n[79:54], |n[53:0]});
    endfunction

    // Rebuild the result from the polynomial and the integer part.
    function automatic logic [31:0] assemble(input logic signed [31:0] m,
                                             input logic [31:0] p);
        logic [31:0]        pb;
        logic signed [31:0] sh;
        logic signed [32:0] sum;
        if (m < C_M_FLOOR) begin
            return 32'h0;
        end
        pb  = ((p[30:23] == 8'hFF) && (p[22:0] != '0)) ? C_QNAN : p;
        sh  = (m > C_M_SHMAX) ? 32'sh7FFF_FFFF : (m <<< 23);
        sum = 33'($signed(pb)) + 33'(sh);
        if (sum > 33'sh0_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        if (sum < -33'sh0_8000_0000) begin
            return 32'h8000_0000;
        end
        return sum[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fexp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fexp_x_if / fexp_y_if - argument and result channels
// Valid/ready channels carrying one binary32 value per lane.
// ----------------------------------------------------------------------------
interface fexp_x_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_lane0;
    logic [31:0] x_lane1;
    logic [31:0] x_lane2;
    logic [31:0] x_lane3;
    modport source (output valid, output x_lane0, output x_lane1, output x_lane2,
                    output x_lane3, input ready);
    modport sink   (input valid, input x_lane0, input x_lane1, input x_lane2,
                    input x_lane3, output ready);
endinterface

interface fexp_y_if;
    logic        valid;
    logic        ready;
    logic [31:0] y_lane0;
    logic [31:0] y_lane1;
    logic [31:0] y_lane2;
    logic [31:0] y_lane3;
    modport source (output valid, output y_lane0, output y_lane1, output y_lane2,
                    output y_lane3, input ready);
    modport sink   (input valid, input y_lane0, input y_lane1, input y_lane2,
                    input y_lane3, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fexp_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fexp_lane - one exponential datapath lane
// Eleven register stages: range reduction, polynomial and exponent rebuild.
// ----------------------------------------------------------------------------
module fexp_lane (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_x,
    output logic      [31:0] o_y
);
    import fexp_pkg::*;

    logic [31:0]        r_s1_x, r_s1_t, r_s2_x, r_s2_mf;
    logic signed [31:0] r_s2_m, r_s3_m, r_s4_m, r_s5_m, r_s6_m, r_s7_m, r_s8_m;
    logic signed [31:0] r_s9_m, r_s10_m;
    t_fma_mid           r_s3_mid;
    logic [31:0]        r_s4_r;
    logic [31:0]        r_s5_p4, r_s5_p5, r_s5_p6, r_s5_p7, r_s5_r2;
    logic [31:0]        r_s6_a, r_s6_b, r_s6_c, r_s6_d, r_s6_r2, r_s6_r4;
    logic [31:0]        r_s7_a, r_s7_c, r_s7_br2, r_s7_dr2, r_s7_r4;
    logic [31:0]        r_s8_lo, r_s8_hi, r_s8_r4;
    logic [31:0]        r_s9_lo, r_s9_t;
    logic [31:0]        r_s10_p, r_s11_y;
    logic signed [31:0] n_m;

    assign n_m = trunc_sat(r_s1_t);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_x   <= i_x;
            r_s1_t   <= fmul(i_x, C_INV_LN2);
            r_s2_x   <= r_s1_x;
            r_s2_m   <= n_m;
            r_s2_mf  <= i2f(n_m);
            r_s3_mid <= fma_align(r_s2_x, r_s2_mf, C_LN2);
            r_s3_m   <= r_s2_m;
            r_s4_r   <= fma_norm(r_s3_mid);
            r_s4_m   <= r_s3_m;
            r_s5_p4  <= fmul(C_POLY[4], r_s4_r);
            r_s5_p5  <= fmul(C_POLY[5], r_s4_r);
            r_s5_p6  <= fmul(C_POLY[6], r_s4_r);
            r_s5_p7  <= fmul(C_POLY[7], r_s4_r);
            r_s5_r2  <= fmul(r_s4_r, r_s4_r);
            r_s5_m   <= r_s4_m;
            r_s6_a   <= fadd(C_POLY[0], r_s5_p4);
            r_s6_b   <= fadd(C_POLY[2], r_s5_p6);
            r_s6_c   <= fadd(C_POLY[1], r_s5_p5);
            r_s6_d   <= fadd(C_POLY[3], r_s5_p7);
            r_s6_r2  <= r_s5_r2;
            r_s6_r4  <= fmul(r_s5_r2, r_s5_r2);
            r_s6_m   <= r_s5_m;
            r_s7_a   <= r_s6_a;
            r_s7_c   <= r_s6_c;
            r_s7_br2 <= fmul(r_s6_b, r_s6_r2);
            r_s7_dr2 <= fmul(r_s6_d, r_s6_r2);
            r_s7_r4  <= r_s6_r4;
            r_s7_m   <= r_s6_m;
            r_s8_lo  <= fadd(r_s7_a, r_s7_br2);
            r_s8_hi  <= fadd(r_s7_c, r_s7_dr2);
            r_s8_r4  <= r_s7_r4;
            r_s8_m   <= r_s7_m;
            r_s9_lo  <= r_s8_lo;
            r_s9_t   <= fmul(r_s8_hi, r_s8_r4);
            r_s9_m   <= r_s8_m;
            r_s10_p  <= fadd(r_s9_lo, r_s9_t);
            r_s10_m  <= r_s9_m;
            r_s11_y  <= assemble(r_s10_m, r_s10_p);
        end
    end

    assign o_y = r_s11_y;

endmodule
`default_nettype wire

// ===== rtl/core/fp32_exp_polynomial_approx.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fp32_exp_polynomial_approx - four-lane binary32 exponential approximation
// Range reduction by ln2 and a degree-7 polynomial, one lane per element.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; the eleven-stage lane pipeline moves
// as a whole and halts only while the output register holds an untaken result.
// Reset: synchronous, active low; it clears the stage valid bits only, the
// data registers are not reset.
module fp32_exp_polynomial_approx (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fexp_x_if.sink    i_x,
    fexp_y_if.source  o_y
);
    import fexp_pkg::*;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic              w_en;
    logic [31:0]       w_x [LANES];
    logic [31:0]       w_y [LANES];

    // The whole pipe advances unless a finished result is waiting to be taken.
    assign w_en      = ~r_vld[STAGES-1] | o_y.ready;
    assign i_x.ready = w_en;
    assign n_vld     = {r_vld[STAGES-2:0], i_x.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    assign w_x[0] = i_x.x_lane0;
    assign w_x[1] = i_x.x_lane1;
    assign w_x[2] = i_x.x_lane2;
    assign w_x[3] = i_x.x_lane3;

    // Each lane is an independent copy of the datapath.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        fexp_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_x[g]),
            .o_y   (w_y[g])
        );
    end

    // The lane output registers together form the result transaction.
    assign o_y.valid   = r_vld[STAGES-1];
    assign o_y.y_lane0 = w_y[0];
    assign o_y.y_lane1 = w_y[1];
    assign o_y.y_lane2 = w_y[2];
    assign o_y.y_lane3 = w_y[3];

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("valid bits not cleared by reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_x.valid && i_x.ready) |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_y.valid && !o_y.ready) |=> $stable(r_vld))
        else $error("pipeline moved while the output was stalled");

endmodule
`default_nettype wire
